>>> hdl/utf8dw_pkg.sv
// Shared types, constants and the character width classifier for the UTF-8 width meter.
`default_nettype none
package utf8dw_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned PosW  = 16;
  localparam int unsigned ColW  = 16;
  localparam int unsigned WidW  = 2;

  localparam logic [ColW-1:0] MaxColumnsReset = 16'd80;

  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] ContMask  = 8'h3F;

  localparam logic [WidW-1:0] WidthZero   = 2'd0;
  localparam logic [WidW-1:0] WidthSingle = 2'd1;
  localparam logic [WidW-1:0] WidthDouble = 2'd2;

  // One decoded character handed from the decoder to the meter.
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [PosW-1:0] offset;
    logic [PosW-1:0] bytes_after;
    logic            incomplete;
    logic            last;
  } char_t;

  // One finished result as shown on the output ports.
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [WidW-1:0] width;
    logic [ColW-1:0] column_after;
    logic [PosW-1:0] char_offset;
    logic            fits;
    logic [PosW-1:0] cut_offset;
    logic            incomplete;
    logic            last;
  } result_t;

  function automatic logic [WidW-1:0] width_of(input logic [CpW-1:0] cp);
    logic [WidW-1:0] w;
    w = WidthSingle;
    if (cp < 21'h20 || cp == 21'h7F) begin
      w = WidthZero;
    end else if ((cp >= 21'h4E00  && cp <= 21'h9FFF)  ||
                 (cp >= 21'h3400  && cp <= 21'h4DBF)  ||
                 (cp >= 21'hF900  && cp <= 21'hFAFF)  ||
                 (cp >= 21'hFF01  && cp <= 21'hFF60)  ||
                 (cp >= 21'hFFE0  && cp <= 21'hFFE6)  ||
                 (cp >= 21'hAC00  && cp <= 21'hD7AF)  ||
                 (cp >= 21'h20000 && cp <= 21'h2FA1F)) begin
      w = WidthDouble;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/utf8dw_fifo.sv
// Small synchronous queue built from registers, used between the pipeline parts.
`default_nettype none
module utf8dw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [Width-1:0] data_o,
  output      logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8dw_decode.sv
// Front part: lenient UTF-8 decoder; tracks byte offsets, emits whole or truncated chars.
`default_nettype none
module utf8dw_decode #(
  parameter int MaxTextBytes = 65535
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               end_of_text_i,
  output      logic               char_valid_o,
  output      utf8dw_pkg::char_t  char_o
);

  logic [utf8dw_pkg::CpW-1:0]  acc_q, acc_d, acc_upd;
  logic [1:0]                  rem_q, rem_d, rem_upd;
  logic [utf8dw_pkg::PosW-1:0] pos_q, pos_d, pos_upd;
  logic [utf8dw_pkg::PosW-1:0] start_q, start_d, start_upd;
  logic                        done, part;
  logic [utf8dw_pkg::CpW-1:0]  cp;

  always_comb begin
    acc_upd   = acc_q;
    rem_upd   = rem_q;
    start_upd = start_q;
    done      = 1'b0;
    part      = 1'b0;
    cp        = '0;

    if (rem_q == 2'd0) begin
      start_upd = pos_q;
      if (!in_byte_i[7]) begin
        cp   = {13'd0, in_byte_i};
        done = 1'b1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        acc_upd = {13'd0, in_byte_i & utf8dw_pkg::Lead2Mask};
        rem_upd = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        acc_upd = {13'd0, in_byte_i & utf8dw_pkg::Lead3Mask};
        rem_upd = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        acc_upd = {13'd0, in_byte_i & utf8dw_pkg::Lead4Mask};
        rem_upd = 2'd3;
      end else begin
        // Stray continuation or invalid lead byte stands for itself.
        cp   = {13'd0, in_byte_i};
        done = 1'b1;
      end
    end else begin
      acc_upd = {acc_q[utf8dw_pkg::CpW-7:0], in_byte_i[5:0]};
      rem_upd = rem_q - 2'd1;
      if (rem_upd == 2'd0) begin
        cp   = acc_upd;
        done = 1'b1;
      end
    end

    pos_upd = (pos_q < utf8dw_pkg::PosW'(MaxTextBytes)) ? pos_q + 1'b1 : pos_q;

    // A sequence cut short by the end of text yields its partial value.
    if (!done && end_of_text_i) begin
      cp   = acc_upd;
      part = 1'b1;
      done = 1'b1;
    end

    acc_d   = acc_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    start_d = start_q;
    if (valid_i) begin
      acc_d   = done ? '0 : acc_upd;
      rem_d   = done ? 2'd0 : rem_upd;
      pos_d   = pos_upd;
      start_d = start_upd;
      if (end_of_text_i) begin
        pos_d   = '0;
        start_d = '0;
      end
    end
  end

  assign char_valid_o       = valid_i && done;
  assign char_o.cp          = cp;
  assign char_o.offset      = start_upd;
  assign char_o.bytes_after = pos_upd;
  assign char_o.incomplete  = part;
  assign char_o.last        = end_of_text_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
    end else begin
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8dw_meter.sv
// Back part: classifies character width, keeps the column total and finds the cut.
`default_nettype none
module utf8dw_meter #(
  parameter int MaxTextBytes = 65535
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire utf8dw_pkg::char_t           char_i,
  input  wire logic [utf8dw_pkg::ColW-1:0] max_columns_i,
  output      utf8dw_pkg::result_t         result_o
);

  logic [utf8dw_pkg::ColW-1:0] total_q, total_d, total_upd;
  logic                        cut_seen_q, cut_seen_d, cut_seen_upd;
  logic [utf8dw_pkg::PosW-1:0] cut_pos_q, cut_pos_d, cut_pos_upd;
  logic [utf8dw_pkg::WidW-1:0] w;
  logic [utf8dw_pkg::ColW:0]   sum;
  logic                        fits;

  always_comb begin
    w            = utf8dw_pkg::width_of(char_i.cp);
    sum          = {1'b0, total_q} + {{(utf8dw_pkg::ColW - 1){1'b0}}, w};
    fits         = 1'b0;
    cut_seen_upd = cut_seen_q;
    cut_pos_upd  = cut_pos_q;
    if (!cut_seen_q) begin
      if (sum > {1'b0, max_columns_i}) begin
        cut_seen_upd = 1'b1;
        cut_pos_upd  = char_i.offset;
      end else begin
        fits = 1'b1;
      end
    end
    total_upd = (sum > (utf8dw_pkg::ColW + 1)'(MaxTextBytes)) ?
                utf8dw_pkg::ColW'(MaxTextBytes) : sum[utf8dw_pkg::ColW-1:0];

    total_d    = total_q;
    cut_seen_d = cut_seen_q;
    cut_pos_d  = cut_pos_q;
    if (valid_i) begin
      if (char_i.last) begin
        total_d    = '0;
        cut_seen_d = 1'b0;
        cut_pos_d  = '0;
      end else begin
        total_d    = total_upd;
        cut_seen_d = cut_seen_upd;
        cut_pos_d  = cut_pos_upd;
      end
    end
  end

  assign result_o.cp           = char_i.cp;
  assign result_o.width        = w;
  assign result_o.column_after = total_upd;
  assign result_o.char_offset  = char_i.offset;
  assign result_o.fits         = fits;
  assign result_o.cut_offset   = cut_seen_upd ? cut_pos_upd : char_i.bytes_after;
  assign result_o.incomplete   = char_i.incomplete;
  assign result_o.last         = char_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      cut_seen_q <= 1'b0;
      cut_pos_q  <= '0;
    end else begin
      total_q    <= total_d;
      cut_seen_q <= cut_seen_d;
      cut_pos_q  <= cut_pos_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8_display_width_truncate_core.sv
// UTF-8 display width meter with truncation cut: top level.
//
// Usage: text bytes enter through a queue-style port. A byte is taken at a
// clock edge where push is high and full is low; end_of_text_i marks the final
// byte of a text. Results leave through a second queue-style port: while empty
// is low the oldest result is on the output ports, and pop at such an edge
// removes it. One result is produced per completed character, and one for the
// final byte of a text even if its sequence was cut short.
// Throughput is one byte per cycle while full is low; the decoder and the meter
// work combinationally on their state. A byte that completes a character goes
// into the character queue at the edge that takes it; a later edge, with the
// result queue not full, moves it through the meter into the result queue.
// When pop stays low the result queue fills, the meter stops draining the
// character queue, and full rises once both two-entry queues are full.
// Reset clears both queues, the decoder and meter state, and loads the column
// budget with 80. The budget is written through cfg_we_i and cfg_wdata_i; the
// user must write it only while no text is in flight, which the block does not
// enforce. After the final byte of a text all per-text state returns to zero.
`default_nettype none
module utf8_display_width_truncate_core #(
  parameter int MaxTextBytes = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [20:0] code_point_o,
  output      logic [1:0]  char_width_o,
  output      logic [15:0] column_after_o,
  output      logic [15:0] char_offset_o,
  output      logic        char_fits_o,
  output      logic [15:0] cut_offset_o,
  output      logic        incomplete_o,
  output      logic        text_last_o
);

  localparam int QueueDepth = 2;

  logic [utf8dw_pkg::ColW-1:0] max_columns_q;
  logic                        in_take;
  logic                        char_valid;
  utf8dw_pkg::char_t           char_dec, char_head;
  logic                        mid_empty;
  logic                        out_full;
  logic                        xfer;
  utf8dw_pkg::result_t         result_new, result_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_columns_q <= utf8dw_pkg::MaxColumnsReset;
    end else if (cfg_we_i) begin
      max_columns_q <= cfg_wdata_i;
    end
  end

  assign in_take = push && !full;

  utf8dw_decode #(
    .MaxTextBytes(MaxTextBytes)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_take),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .char_valid_o (char_valid),
    .char_o       (char_dec)
  );

  utf8dw_fifo #(
    .Width($bits(utf8dw_pkg::char_t)),
    .Depth(QueueDepth)
  ) u_char_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (char_valid),
    .data_i (char_dec),
    .full_o (full),
    .pop_i  (xfer),
    .data_o (char_head),
    .empty_o(mid_empty)
  );

  assign xfer = !mid_empty && !out_full;

  utf8dw_meter #(
    .MaxTextBytes(MaxTextBytes)
  ) u_meter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (xfer),
    .char_i       (char_head),
    .max_columns_i(max_columns_q),
    .result_o     (result_new)
  );

  utf8dw_fifo #(
    .Width($bits(utf8dw_pkg::result_t)),
    .Depth(QueueDepth)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (xfer),
    .data_i (result_new),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (result_head),
    .empty_o(empty)
  );

  assign code_point_o   = result_head.cp;
  assign char_width_o   = result_head.width;
  assign column_after_o = result_head.column_after;
  assign char_offset_o  = result_head.char_offset;
  assign char_fits_o    = result_head.fits;
  assign cut_offset_o   = result_head.cut_offset;
  assign incomplete_o   = result_head.incomplete;
  assign text_last_o    = result_head.last;

endmodule
`default_nettype wire

>>> hdl/utf8dw_checker.sv
// Port-level checks on the width meter's results, bound to the top level.
`default_nettype none
module utf8dw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [20:0] code_point_o,
  input wire logic [1:0]  char_width_o,
  input wire logic [15:0] char_offset_o,
  input wire logic        char_fits_o,
  input wire logic [15:0] cut_offset_o,
  input wire logic        incomplete_o,
  input wire logic        text_last_o
);

  // A zero-width result must be a control code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_width_o == utf8dw_pkg::WidthZero) |->
      (code_point_o < 21'h20 || code_point_o == 21'h7F))
    else $error("zero width given to a printable code point");

  // A truncated sequence can only be reported on the final byte of a text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && incomplete_o) |-> text_last_o)
    else $error("incomplete character reported before end of text");

  // Before any cut, the reported length covers the current character start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_fits_o) |-> (cut_offset_o >= char_offset_o))
    else $error("cut offset lies before a character that still fits");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_point_o) && $stable(cut_offset_o)))
    else $error("waiting result changed or vanished without pop");

endmodule

bind utf8_display_width_truncate_core utf8dw_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .code_point_o (code_point_o),
  .char_width_o (char_width_o),
  .char_offset_o(char_offset_o),
  .char_fits_o  (char_fits_o),
  .cut_offset_o (cut_offset_o),
  .incomplete_o (incomplete_o),
  .text_last_o  (text_last_o)
);
`default_nettype wire
